>>> hdl/dat_pkg.sv
// dat_pkg: types, constants and helper functions of the dirty area tracker
// used by the interfaces, the tracker top level and its checker
`default_nettype none

package dat_pkg;

  localparam int BUF_DEPTH_DEF  = 32;
  localparam int COORD_BITS_DEF = 16;
  localparam int IN_COORD_W     = 16;
  localparam int EXT_W          = 17;
  localparam int SCR_W          = 13;
  localparam int POS_W          = 12;
  localparam int SIZE_W         = 26;
  localparam int PIX_W          = 29;
  localparam int CNT_OUT_W      = 6;
  localparam int POP_W          = 16;
  localparam int APB_DW         = 32;
  localparam int APB_AW         = 3;

  localparam logic [SCR_W-1:0] SCR_W_RST = 13'd480;
  localparam logic [SCR_W-1:0] SCR_H_RST = 13'd320;
  localparam logic [SCR_W-1:0] RES_MAX   = 13'd4096;
  localparam logic [PIX_W-1:0] PIX_MAX   = {PIX_W{1'b1}};

  // register index codes, taken from paddr[2]
  localparam logic REG_SCR_W = 1'b0;
  localparam logic REG_SCR_H = 1'b1;

  typedef enum logic [1:0] {
    OP_INV   = 2'd0,
    OP_CLR   = 2'd1,
    OP_POP   = 2'd2,
    OP_FLUSH = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RES, S_INV_RD, S_INV_CHK, S_INV_WR,
    S_MA_RD, S_MA_LD, S_MB_RD, S_MB_MUL, S_MB_CMP, S_MA_WB,
    S_LAST, S_EM_RD, S_EM_MUL, S_EM_OUT
  } state_t;

  typedef struct packed {
    logic [POS_W-1:0] x1;
    logic [POS_W-1:0] y1;
    logic [POS_W-1:0] x2;
    logic [POS_W-1:0] y2;
  } area_t;

  typedef struct packed {
    logic  rev;
    area_t area;
  } entry_t;

  typedef struct packed {
    logic                 has_area;
    area_t                area;
    logic                 rev;
    logic                 last;
    logic [CNT_OUT_W-1:0] cnt;
    logic [PIX_W-1:0]     pix;
  } result_t;

  function automatic logic [SIZE_W-1:0] area_size(area_t a);
    logic [SCR_W-1:0] w;
    logic [SCR_W-1:0] h;
    w = {1'b0, a.x2} - {1'b0, a.x1} + 13'd1;
    h = {1'b0, a.y2} - {1'b0, a.y1} + 13'd1;
    return {13'd0, w} * {13'd0, h};
  endfunction

  function automatic logic is_inside(area_t a, area_t b);
    return (a.x1 >= b.x1) && (a.y1 >= b.y1) && (a.x2 <= b.x2) && (a.y2 <= b.y2);
  endfunction

  function automatic logic overlaps(area_t a, area_t b);
    return (a.x1 <= b.x2) && (a.x2 >= b.x1) && (a.y1 <= b.y2) && (a.y2 >= b.y1);
  endfunction

  function automatic area_t bbox(area_t a, area_t b);
    area_t r;
    r.x1 = (a.x1 < b.x1) ? a.x1 : b.x1;
    r.y1 = (a.y1 < b.y1) ? a.y1 : b.y1;
    r.x2 = (a.x2 > b.x2) ? a.x2 : b.x2;
    r.y2 = (a.y2 > b.y2) ? a.y2 : b.y2;
    return r;
  endfunction

  // largest pixel index for a resolution register, 0 read as 1, resolution capped at 4096
  function automatic logic [POS_W-1:0] res_last(logic [SCR_W-1:0] r);
    logic [SCR_W-1:0] m;
    m = (r == '0) ? 13'd1 : ((r > RES_MAX) ? RES_MAX : r);
    m = m - 13'd1;
    return m[POS_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> hdl/dat_if.sv
// dat_in_if and dat_out_if: valid/ready channels of the dirty area tracker
// depends on dat_pkg for field widths
`default_nettype none

interface dat_in_if;
  import dat_pkg::*;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   operation;
  logic signed [IN_COORD_W-1:0] left_x;
  logic signed [IN_COORD_W-1:0] top_y;
  logic signed [IN_COORD_W-1:0] right_x;
  logic signed [IN_COORD_W-1:0] bottom_y;
  logic                         reverse_order;
  logic [POP_W-1:0]             pop_count;

  modport source (output valid, operation, left_x, top_y, right_x, bottom_y,
                  reverse_order, pop_count, input ready);
  modport sink   (input valid, operation, left_x, top_y, right_x, bottom_y,
                  reverse_order, pop_count, output ready);
endinterface

interface dat_out_if;
  import dat_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 out_valid;
  logic [POS_W-1:0]     out_left;
  logic [POS_W-1:0]     out_top;
  logic [POS_W-1:0]     out_right;
  logic [POS_W-1:0]     out_bottom;
  logic                 out_reverse;
  logic                 is_last;
  logic [CNT_OUT_W-1:0] count_now;
  logic [PIX_W-1:0]     pixel_sum;

  modport source (output valid, out_valid, out_left, out_top, out_right, out_bottom,
                  out_reverse, is_last, count_now, pixel_sum, input ready);
  modport sink   (input valid, out_valid, out_left, out_top, out_right, out_bottom,
                  out_reverse, is_last, count_now, pixel_sum, output ready);
endinterface

`default_nettype wire

>>> hdl/dirty_area_tracker.sv
// dirty_area_tracker: buffer of dirty screen areas with invalidate, clear,
// pop and flush-with-join; depends on dat_pkg, dat_if and dat_ram
//
//  channel   | dir | handshake          | carries
//  ----------+-----+--------------------+------------------------------------
//  in_item   | in  | valid/ready        | operation, corners, flag, pop count
//  out_item  | out | valid/ready        | area, flag, is_last, count, pixel sum
//  cfg_*     | in  | apb, pready high   | screen_width @0x0, screen_height @0x4
//
// one item at a time; invalidate runs a containment scan, one ram read per
// stored area; flush duration is set by the join pass, which reads every
// other area through the single ram read port
// rst_n is synchronous; the area ram is not cleared, only the count is
// a stalled result holds the next result back; a new item is taken as soon
// as the block is idle, even while the last result still waits
`default_nettype none

module dirty_area_tracker #(
  parameter int BUFFER_DEPTH = dat_pkg::BUF_DEPTH_DEF,
  parameter int COORD_BITS   = dat_pkg::COORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  dat_in_if.sink                      in_item,
  dat_out_if.source                   out_item,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [dat_pkg::APB_AW-1:0]  cfg_paddr,
  input  logic [dat_pkg::APB_DW-1:0]  cfg_pwdata,
  output logic [dat_pkg::APB_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);

  import dat_pkg::*;

  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int CW = $clog2(BUFFER_DEPTH + 1);
  localparam int EW = $bits(entry_t);
  localparam logic [CW-1:0] DEPTH_C = CW'(BUFFER_DEPTH);

  // control state
  state_t               state_r, state_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [CW-1:0]        idx_r, idx_nxt;     // scan index: stored area, join partner or emit
  logic [CW-1:0]        a_r, a_nxt;         // area that is growing during join
  logic [CW-1:0]        last_r, last_nxt;   // index of final unmerged area
  logic [BUFFER_DEPTH-1:0] merged_r, merged_nxt;
  logic                 oval_r, oval_nxt;
  logic [SCR_W-1:0]     scr_w_r, scr_h_r;

  // datapath registers
  entry_t               ci_r, ci_nxt;       // clipped area of an invalidate
  entry_t               ra_r, ra_nxt;
  area_t                j_r, j_nxt;
  logic                 ov_r, ov_nxt;
  logic [SIZE_W-1:0]    pj_r, pj_nxt, pa_r, pa_nxt, pb_r, pb_nxt;
  entry_t               e_r, e_nxt;
  logic [SIZE_W-1:0]    es_r, es_nxt;
  logic [PIX_W-1:0]     sum_r, sum_nxt;
  result_t              res_r, res_nxt;

  // ram port
  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  entry_t               ram_wdata;
  logic [EW-1:0]        ram_rdata;
  entry_t               rd;

  // misc
  logic                 acc, slot_free;
  logic [POS_W-1:0]     wm1, hm1;
  area_t                full_scr;
  logic signed [EXT_W-1:0] sx1, sy1, sx2, sy2, cx1, cy1, cx2, cy2, wm1s, hm1s;
  logic                 clip_empty;
  logic [CW-1:0]        idx_m1;
  logic [PIX_W:0]       sum_w;
  logic [PIX_W-1:0]     sum_sat;

  dat_ram #(.WIDTH(EW), .DEPTH(BUFFER_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd = entry_t'(ram_rdata);

  // handshakes
  assign in_item.ready = (state_r == S_IDLE);
  assign acc           = in_item.valid && in_item.ready;
  assign slot_free     = !oval_r || out_item.ready;

  assign out_item.valid       = oval_r;
  assign out_item.out_valid   = res_r.has_area;
  assign out_item.out_left    = res_r.area.x1;
  assign out_item.out_top     = res_r.area.y1;
  assign out_item.out_right   = res_r.area.x2;
  assign out_item.out_bottom  = res_r.area.y2;
  assign out_item.out_reverse = res_r.rev;
  assign out_item.is_last     = res_r.last;
  assign out_item.count_now   = res_r.cnt;
  assign out_item.pixel_sum   = res_r.pix;

  // configuration port, decoded on paddr[2]
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_SCR_H) ? APB_DW'(scr_h_r) : APB_DW'(scr_w_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_w_r <= SCR_W_RST;
      scr_h_r <= SCR_H_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      if (cfg_paddr[2] == REG_SCR_W) begin
        scr_w_r <= cfg_pwdata[SCR_W-1:0];
      end else begin
        scr_h_r <= cfg_pwdata[SCR_W-1:0];
      end
    end
  end

  // screen bounds
  assign wm1      = res_last(scr_w_r);
  assign hm1      = res_last(scr_h_r);
  assign full_scr = '{x1: '0, y1: '0, x2: wm1, y2: hm1};
  assign wm1s     = $signed({{(EXT_W-POS_W){1'b0}}, wm1});
  assign hm1s     = $signed({{(EXT_W-POS_W){1'b0}}, hm1});

  // incoming corners: low COORD_BITS bits, sign extended, clipped to screen
  assign sx1 = $signed({{(EXT_W-COORD_BITS){in_item.left_x[COORD_BITS-1]}},
                        in_item.left_x[COORD_BITS-1:0]});
  assign sy1 = $signed({{(EXT_W-COORD_BITS){in_item.top_y[COORD_BITS-1]}},
                        in_item.top_y[COORD_BITS-1:0]});
  assign sx2 = $signed({{(EXT_W-COORD_BITS){in_item.right_x[COORD_BITS-1]}},
                        in_item.right_x[COORD_BITS-1:0]});
  assign sy2 = $signed({{(EXT_W-COORD_BITS){in_item.bottom_y[COORD_BITS-1]}},
                        in_item.bottom_y[COORD_BITS-1:0]});
  assign cx1 = sx1[EXT_W-1] ? '0 : sx1;
  assign cy1 = sy1[EXT_W-1] ? '0 : sy1;
  assign cx2 = (sx2 > wm1s) ? wm1s : sx2;
  assign cy2 = (sy2 > hm1s) ? hm1s : sy2;
  assign clip_empty = (cx1 > cx2) || (cy1 > cy2);

  assign idx_m1 = idx_r - CW'(1);

  // saturating running pixel sum
  assign sum_w   = {1'b0, sum_r} + (PIX_W+1)'(es_r);
  assign sum_sat = (sum_w > {1'b0, PIX_MAX}) ? PIX_MAX : sum_w[PIX_W-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          case (op_t'(in_item.operation))
            OP_INV:   state_nxt = clip_empty ? S_RES : S_INV_RD;
            OP_FLUSH: state_nxt = S_MA_RD;
            default:  state_nxt = S_RES;
          endcase
        end
      end
      S_RES: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      S_INV_RD: begin
        state_nxt = (idx_r == cnt_r) ? S_INV_WR : S_INV_CHK;
      end
      S_INV_CHK: begin
        state_nxt = is_inside(ci_r.area, rd.area) ? S_RES : S_INV_RD;
      end
      S_INV_WR: state_nxt = S_RES;
      S_MA_RD: begin
        if (a_r == cnt_r) begin
          state_nxt = S_LAST;
        end else if (!merged_r[a_r[AW-1:0]]) begin
          state_nxt = S_MA_LD;
        end
      end
      S_MA_LD: state_nxt = S_MB_RD;
      S_MB_RD: begin
        if (idx_r == cnt_r) begin
          state_nxt = S_MA_WB;
        end else if (!merged_r[idx_r[AW-1:0]] && (idx_r != a_r)) begin
          state_nxt = S_MB_MUL;
        end
      end
      S_MB_MUL: state_nxt = S_MB_CMP;
      S_MB_CMP: state_nxt = S_MB_RD;
      S_MA_WB:  state_nxt = S_MA_RD;
      S_LAST: begin
        if (idx_r == '0) begin
          if (slot_free) state_nxt = S_IDLE;
        end else if (!merged_r[idx_m1[AW-1:0]]) begin
          state_nxt = S_EM_RD;
        end
      end
      S_EM_RD: begin
        if (!merged_r[idx_r[AW-1:0]]) state_nxt = S_EM_MUL;
      end
      S_EM_MUL: state_nxt = S_EM_OUT;
      S_EM_OUT: begin
        if (slot_free) state_nxt = (idx_r == last_r) ? S_IDLE : S_EM_RD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath, ram control and result register
  always_comb begin
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    a_nxt      = a_r;
    last_nxt   = last_r;
    merged_nxt = merged_r;
    oval_nxt   = (oval_r && !out_item.ready);
    ci_nxt     = ci_r;
    ra_nxt     = ra_r;
    j_nxt      = j_r;
    ov_nxt     = ov_r;
    pj_nxt     = pj_r;
    pa_nxt     = pa_r;
    pb_nxt     = pb_r;
    e_nxt      = e_r;
    es_nxt     = es_r;
    sum_nxt    = sum_r;
    res_nxt    = res_r;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = ra_r;
    ram_re     = 1'b0;
    ram_raddr  = idx_r[AW-1:0];
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          idx_nxt = '0;
          a_nxt   = '0;
          sum_nxt = '0;
          ci_nxt  = '{rev: in_item.reverse_order,
                      area: '{x1: cx1[POS_W-1:0], y1: cy1[POS_W-1:0],
                              x2: cx2[POS_W-1:0], y2: cy2[POS_W-1:0]}};
          case (op_t'(in_item.operation))
            OP_CLR: cnt_nxt = '0;
            OP_POP: begin
              if (in_item.pop_count > POP_W'(cnt_r)) begin
                cnt_nxt = '0;
              end else begin
                cnt_nxt = cnt_r - in_item.pop_count[CW-1:0];
              end
            end
            default: ;
          endcase
        end
      end
      S_RES: begin
        if (slot_free) begin
          oval_nxt = 1'b1;
          res_nxt  = '{has_area: 1'b0, area: '0, rev: 1'b0, last: 1'b1,
                       cnt: CNT_OUT_W'(cnt_r), pix: '0};
        end
      end
      S_INV_RD: begin
        if (idx_r != cnt_r) ram_re = 1'b1;
      end
      S_INV_CHK: idx_nxt = idx_r + CW'(1);
      S_INV_WR: begin
        // full buffer restarts with the whole screen
        ram_we = 1'b1;
        if (cnt_r < DEPTH_C) begin
          ram_waddr = cnt_r[AW-1:0];
          ram_wdata = ci_r;
          cnt_nxt   = cnt_r + CW'(1);
        end else begin
          ram_waddr = '0;
          ram_wdata = '{rev: ci_r.rev, area: full_scr};
          cnt_nxt   = CW'(1);
        end
      end
      S_MA_RD: begin
        ram_raddr = a_r[AW-1:0];
        if (a_r == cnt_r) begin
          idx_nxt = cnt_r;
        end else if (merged_r[a_r[AW-1:0]]) begin
          a_nxt = a_r + CW'(1);
        end else begin
          ram_re = 1'b1;
        end
      end
      S_MA_LD: begin
        ra_nxt  = rd;
        idx_nxt = '0;
      end
      S_MB_RD: begin
        if (idx_r != cnt_r) begin
          if (merged_r[idx_r[AW-1:0]] || (idx_r == a_r)) begin
            idx_nxt = idx_r + CW'(1);
          end else begin
            ram_re = 1'b1;
          end
        end
      end
      S_MB_MUL: begin
        j_nxt  = bbox(ra_r.area, rd.area);
        ov_nxt = overlaps(ra_r.area, rd.area);
        pj_nxt = area_size(bbox(ra_r.area, rd.area));
        pa_nxt = area_size(ra_r.area);
        pb_nxt = area_size(rd.area);
      end
      S_MB_CMP: begin
        if (ov_r && ({1'b0, pj_r} < ({1'b0, pa_r} + {1'b0, pb_r}))) begin
          ra_nxt.area                  = j_r;
          merged_nxt[idx_r[AW-1:0]] = 1'b1;
        end
        idx_nxt = idx_r + CW'(1);
      end
      S_MA_WB: begin
        ram_we    = 1'b1;
        ram_waddr = a_r[AW-1:0];
        ram_wdata = ra_r;
        a_nxt     = a_r + CW'(1);
      end
      S_LAST: begin
        if (idx_r == '0) begin
          // nothing left to emit
          if (slot_free) begin
            oval_nxt   = 1'b1;
            res_nxt    = '{has_area: 1'b0, area: '0, rev: 1'b0, last: 1'b1,
                           cnt: '0, pix: '0};
            cnt_nxt    = '0;
            merged_nxt = '0;
          end
        end else if (!merged_r[idx_m1[AW-1:0]]) begin
          last_nxt = idx_m1;
          idx_nxt  = '0;
        end else begin
          idx_nxt = idx_m1;
        end
      end
      S_EM_RD: begin
        if (merged_r[idx_r[AW-1:0]]) begin
          idx_nxt = idx_r + CW'(1);
        end else begin
          ram_re = 1'b1;
        end
      end
      S_EM_MUL: begin
        e_nxt  = rd;
        es_nxt = area_size(rd.area);
      end
      S_EM_OUT: begin
        if (slot_free) begin
          oval_nxt = 1'b1;
          sum_nxt  = sum_sat;
          res_nxt  = '{has_area: 1'b1, area: e_r.area, rev: e_r.rev,
                       last: (idx_r == last_r), cnt: '0, pix: sum_sat};
          idx_nxt  = idx_r + CW'(1);
          if (idx_r == last_r) begin
            cnt_nxt    = '0;
            merged_nxt = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      idx_r    <= '0;
      a_r      <= '0;
      last_r   <= '0;
      merged_r <= '0;
      oval_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      idx_r    <= idx_nxt;
      a_r      <= a_nxt;
      last_r   <= last_nxt;
      merged_r <= merged_nxt;
      oval_r   <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ci_r  <= ci_nxt;
    ra_r  <= ra_nxt;
    j_r   <= j_nxt;
    ov_r  <= ov_nxt;
    pj_r  <= pj_nxt;
    pa_r  <= pa_nxt;
    pb_r  <= pb_nxt;
    e_r   <= e_nxt;
    es_r  <= es_nxt;
    sum_r <= sum_nxt;
    res_r <= res_nxt;
  end

endmodule

`default_nettype wire

>>> hdl/dat_ram.sv
// dat_ram: generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module dat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hdl/dat_checker.sv
// dat_checker: port-level assertions on the dirty area tracker results
// depends on dat_pkg; bound to dirty_area_tracker at the end of the file
`default_nettype none

module dat_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          o_valid,
  input logic                          o_ready,
  input logic                          o_has_area,
  input logic [dat_pkg::POS_W-1:0]     o_left,
  input logic [dat_pkg::POS_W-1:0]     o_top,
  input logic [dat_pkg::POS_W-1:0]     o_right,
  input logic [dat_pkg::POS_W-1:0]     o_bottom,
  input logic                          o_last,
  input logic [dat_pkg::CNT_OUT_W-1:0] o_cnt,
  input logic [dat_pkg::PIX_W-1:0]     o_pix
);

  import dat_pkg::*;

  // stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid && !o_ready |=> o_valid)
    else $error("result dropped while stalled");

  // a result without an area ends its item and carries no pixels
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid && !o_has_area |-> o_last && (o_pix == '0) && (o_left == '0) &&
                                (o_right == '0))
    else $error("empty result malformed");

  // emitted areas come from a flush, which leaves the buffer empty
  a_flush_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid && o_has_area |-> (o_cnt == '0))
    else $error("flush result with nonzero count");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid && o_has_area |-> (o_left <= o_right) && (o_top <= o_bottom))
    else $error("emitted area inverted");

endmodule

bind dirty_area_tracker dat_checker u_dat_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .o_valid    (out_item.valid),
  .o_ready    (out_item.ready),
  .o_has_area (out_item.out_valid),
  .o_left     (out_item.out_left),
  .o_top      (out_item.out_top),
  .o_right    (out_item.out_right),
  .o_bottom   (out_item.out_bottom),
  .o_last     (out_item.is_last),
  .o_cnt      (out_item.count_now),
  .o_pix      (out_item.pixel_sum)
);

`default_nettype wire

>>> dv/dat_checker.sv
// dat_scoreboard: watches the item channels and config port of the dirty area tracker,
// predicts every result item and compares it field by field
// depends on dat_pkg and dat_if
`timescale 1ns / 100ps

module dat_scoreboard (
  input  logic                       clk,
  input  logic                       rst_n,
  dat_in_if                          in_mon,
  dat_out_if                         out_mon,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [dat_pkg::APB_AW-1:0] cfg_paddr,
  input  logic [dat_pkg::APB_DW-1:0] cfg_pwdata,
  input  logic                       cfg_pready,
  output int                         fails,
  output int                         pending
);
  import dat_pkg::*;

  localparam int DEPTH = 32;

  logic [SCR_W-1:0] width_reg;
  logic [SCR_W-1:0] height_reg;
  int   sx1 [DEPTH];
  int   sy1 [DEPTH];
  int   sx2 [DEPTH];
  int   sy2 [DEPTH];
  bit   srev [DEPTH];
  int   held;
  result_t due_q [$];

  initial fails = 0;

  function automatic int res_eff(logic [SCR_W-1:0] r);
    if (r == 0) return 1;
    if (r > 4096) return 4096;
    return int'(r);
  endfunction

  function automatic longint dim(int x1, int y1, int x2, int y2);
    return longint'(x2 - x1 + 1) * longint'(y2 - y1 + 1);
  endfunction

  function automatic result_t plain_result(int cnt);
    result_t r;
    r = '0;
    r.last = 1'b1;
    r.cnt = cnt[CNT_OUT_W-1:0];
    return r;
  endfunction

  task automatic add_area(int lx, int ty, int rx, int by, bit rev);
    int wl;
    int hl;
    wl = res_eff(width_reg) - 1;
    hl = res_eff(height_reg) - 1;
    if (lx < 0) lx = 0;
    if (ty < 0) ty = 0;
    if (rx > wl) rx = wl;
    if (by > hl) by = hl;
    if (lx > rx || ty > by) return;
    for (int i = 0; i < held; i++)
      if (lx >= sx1[i] && ty >= sy1[i] && rx <= sx2[i] && by <= sy2[i]) return;
    if (held < DEPTH) begin
      sx1[held] = lx; sy1[held] = ty; sx2[held] = rx; sy2[held] = by;
    end else begin
      // overflow: restart with the whole screen
      held = 0;
      sx1[0] = 0; sy1[0] = 0; sx2[0] = wl; sy2[0] = hl;
    end
    srev[held] = rev;
    held++;
  endtask

  task automatic flush_areas();
    bit      mrg [DEPTH];
    int      bx1, by1, bx2, by2;
    int      last;
    longint  sum;
    result_t r;
    last = -1;
    sum = 0;
    foreach (mrg[i]) mrg[i] = 0;
    for (int a = 0; a < held; a++) begin
      if (mrg[a]) continue;
      for (int b = 0; b < held; b++) begin
        if (mrg[b] || a == b) continue;
        if (!(sx1[a] <= sx2[b] && sx2[a] >= sx1[b] && sy1[a] <= sy2[b] && sy2[a] >= sy1[b]))
          continue;
        bx1 = (sx1[a] < sx1[b]) ? sx1[a] : sx1[b];
        by1 = (sy1[a] < sy1[b]) ? sy1[a] : sy1[b];
        bx2 = (sx2[a] > sx2[b]) ? sx2[a] : sx2[b];
        by2 = (sy2[a] > sy2[b]) ? sy2[a] : sy2[b];
        if (dim(bx1, by1, bx2, by2) <
            dim(sx1[a], sy1[a], sx2[a], sy2[a]) + dim(sx1[b], sy1[b], sx2[b], sy2[b])) begin
          sx1[a] = bx1; sy1[a] = by1; sx2[a] = bx2; sy2[a] = by2;
          mrg[b] = 1;
        end
      end
    end
    for (int a = 0; a < held; a++)
      if (!mrg[a]) last = a;
    for (int a = 0; a < held; a++) begin
      if (mrg[a]) continue;
      sum += dim(sx1[a], sy1[a], sx2[a], sy2[a]);
      if (sum > PIX_MAX) sum = PIX_MAX;
      r = '0;
      r.has_area = 1'b1;
      r.area.x1 = sx1[a][POS_W-1:0];
      r.area.y1 = sy1[a][POS_W-1:0];
      r.area.x2 = sx2[a][POS_W-1:0];
      r.area.y2 = sy2[a][POS_W-1:0];
      r.rev = srev[a];
      r.last = (a == last);
      r.pix = sum[PIX_W-1:0];
      due_q.push_back(r);
    end
    if (last < 0) due_q.push_back(plain_result(0));
    held = 0;
  endtask

  task cmp(string name, longint e, longint g);
    if (e != g) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, e, g);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    result_t e;
    if (!rst_n) begin
      width_reg = SCR_W_RST;
      height_reg = SCR_H_RST;
      held = 0;
      due_q.delete();
    end else begin
      // result item side
      if (out_mon.valid && out_mon.ready) begin
        if (due_q.size() == 0) begin
          $display("%0t ns: result item with nothing expected, actual area %0d,%0d,%0d,%0d",
                   $time, out_mon.out_left, out_mon.out_top, out_mon.out_right,
                   out_mon.out_bottom);
          fails++;
        end else begin
          e = due_q.pop_front();
          cmp("out_valid", longint'(e.has_area), longint'(out_mon.out_valid));
          cmp("out_left", longint'(e.area.x1), longint'(out_mon.out_left));
          cmp("out_top", longint'(e.area.y1), longint'(out_mon.out_top));
          cmp("out_right", longint'(e.area.x2), longint'(out_mon.out_right));
          cmp("out_bottom", longint'(e.area.y2), longint'(out_mon.out_bottom));
          cmp("out_reverse", longint'(e.rev), longint'(out_mon.out_reverse));
          cmp("is_last", longint'(e.last), longint'(out_mon.is_last));
          cmp("count_now", longint'(e.cnt), longint'(out_mon.count_now));
          cmp("pixel_sum", longint'(e.pix), longint'(out_mon.pixel_sum));
        end
      end
      // input item side
      if (in_mon.valid && in_mon.ready) begin
        case (op_t'(in_mon.operation))
          OP_INV: begin
            add_area(int'(in_mon.left_x), int'(in_mon.top_y), int'(in_mon.right_x),
                     int'(in_mon.bottom_y), in_mon.reverse_order);
            due_q.push_back(plain_result(held));
          end
          OP_CLR: begin
            held = 0;
            due_q.push_back(plain_result(held));
          end
          OP_POP: begin
            held = (int'(in_mon.pop_count) > held) ? 0 : held - int'(in_mon.pop_count);
            due_q.push_back(plain_result(held));
          end
          default: flush_areas();
        endcase
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[2])
          REG_SCR_W: width_reg = cfg_pwdata[SCR_W-1:0];
          default:   height_reg = cfg_pwdata[SCR_W-1:0];
        endcase
      end
    end
    pending <= due_q.size();
  end

endmodule

>>> dv/tb.sv
// tb: stimulus and verdict for the dirty area tracker
// depends on dat_pkg, dat_if, the tracker rtl and dat_scoreboard
`timescale 1ns / 100ps

module tb;
  import dat_pkg::*;

  // no accepted item on either side for this long means a hang
  localparam int STALL_LIMIT = 40000;

  typedef struct {
    op_t         op;
    logic [15:0] lx, ty, rx, by;
    logic        rev;
    logic [15:0] pop;
  } stim_t;

  logic clk;
  logic rst_n;
  logic              cfg_psel, cfg_penable, cfg_pwrite;
  logic [APB_AW-1:0] cfg_paddr;
  logic [APB_DW-1:0] cfg_pwdata;
  logic [APB_DW-1:0] cfg_prdata;
  logic              cfg_pready;
  int  fails;
  int  pending;
  bit  calm;      // no idling on either side while set
  int  scr_w, scr_h;   // effective resolution, for shaping stimulus
  int  quiet;

  dat_in_if  in_item ();
  dat_out_if out_item ();

  dirty_area_tracker uut (
    .clk(clk), .rst_n(rst_n), .in_item(in_item), .out_item(out_item),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  dat_scoreboard chk (
    .clk(clk), .rst_n(rst_n), .in_mon(in_item), .out_mon(out_item),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_pready(cfg_pready),
    .fails(fails), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side back-pressure
  initial out_item.ready = 1'b0;
  always @(posedge clk) begin
    out_item.ready <= calm ? 1'b1 : ($urandom_range(99) >= 22);
  end

  // watchdog on accepted items
  always @(posedge clk) begin
    if (!rst_n || (in_item.valid && in_item.ready) || (out_item.valid && out_item.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= STALL_LIMIT) begin
        $display("dirty_area_tracker regression: fail");
        $finish;
      end
    end
  end

  function automatic int res_eff(int r);
    if (r == 0) return 1;
    if (r > 4096) return 4096;
    return r;
  endfunction

  // apb write, setup then access phase, then the bus returns to idle
  task automatic reg_write(logic reg_idx, int value);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {reg_idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_screen(int w, int h);
    reg_write(REG_SCR_W, w);
    reg_write(REG_SCR_H, h);
    scr_w = res_eff(w & 16'h1fff);
    scr_h = res_eff(h & 16'h1fff);
  endtask

  // stop sending and wait until every expected result item is back
  task automatic drain();
    in_item.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic send(stim_t s);
    if (!calm && $urandom_range(99) < 22) begin
      in_item.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_item.valid         <= 1'b1;
    in_item.operation     <= s.op;
    in_item.left_x        <= s.lx;
    in_item.top_y         <= s.ty;
    in_item.right_x       <= s.rx;
    in_item.bottom_y      <= s.by;
    in_item.reverse_order <= s.rev;
    in_item.pop_count     <= s.pop;
    do @(posedge clk); while (!in_item.ready);
  endtask

  function automatic stim_t mk(op_t op, int lx, int ty, int rx, int by, bit rev, int pop);
    stim_t s;
    s.op = op; s.lx = 16'(lx); s.ty = 16'(ty); s.rx = 16'(rx); s.by = 16'(by);
    s.rev = rev; s.pop = 16'(pop);
    return s;
  endfunction

  // mostly on screen, some just off the edges, some anywhere in 16 bits
  function automatic int pick_pos(int lim);
    int r;
    r = $urandom_range(99);
    if (r < 8) return $urandom_range(65535);
    if (r < 13) return -$urandom_range(1, 40);
    if (r < 18) return lim + $urandom_range(0, 40);
    return $urandom_range(0, lim - 1);
  endfunction

  function automatic stim_t rand_item();
    stim_t s;
    int r;
    s.lx = 16'(pick_pos(scr_w));
    s.ty = 16'(pick_pos(scr_h));
    s.rx = 16'(($urandom_range(99) < 85) ? s.lx + $urandom_range(0, scr_w / 3 + 1)
                                         : pick_pos(scr_w));
    s.by = 16'(($urandom_range(99) < 85) ? s.ty + $urandom_range(0, scr_h / 3 + 1)
                                         : pick_pos(scr_h));
    s.rev = 1'($urandom_range(1));
    s.pop = 16'(($urandom_range(1)) ? $urandom_range(65535) : $urandom_range(0, 4));
    r = $urandom_range(99);
    if (r < 70) s.op = OP_INV;
    else if (r < 74) s.op = OP_CLR;
    else if (r < 80) s.op = OP_POP;
    else s.op = OP_FLUSH;
    return s;
  endfunction

  task automatic random_run(int n);
    for (int i = 0; i < n; i++) send(rand_item());
  endtask

  initial begin
    calm = 1'b0;
    rst_n = 1'b0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    cfg_paddr = '0; cfg_pwdata = '0;
    in_item.valid = 1'b0;
    in_item.operation = '0;
    in_item.left_x = '0; in_item.top_y = '0; in_item.right_x = '0; in_item.bottom_y = '0;
    in_item.reverse_order = 1'b0;
    in_item.pop_count = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part on the default-sized screen
    set_screen(480, 320);
    send(mk(OP_INV, -32768, -32768, 32767, 32767, 1, 0));  // whole screen after clipping
    send(mk(OP_INV, 10, 10, 20, 20, 0, 0));                // inside a stored area
    send(mk(OP_FLUSH, 0, 0, 0, 0, 0, 0));
    send(mk(OP_INV, 5, 5, 4, 9, 1, 0));                    // empty area
    send(mk(OP_INV, -1, -1, -1, -1, 1, 65535));            // empty after clipping
    send(mk(OP_INV, 0, 0, 10, 10, 0, 0));
    send(mk(OP_INV, 0, 5, 10, 15, 1, 0));                  // joins with the one above
    send(mk(OP_INV, 100, 110, 200, 112, 0, 0));
    send(mk(OP_INV, 150, 100, 152, 200, 1, 0));            // cross shape, kept apart
    send(mk(OP_INV, 479, 319, 600, 900, 1, 0));            // bottom right pixel
    send(mk(OP_INV, 32767, 0, 32767, 5, 0, 0));            // off to the right
    send(mk(OP_FLUSH, 0, 0, 0, 0, 0, 0));
    send(mk(OP_FLUSH, 0, 0, 0, 0, 0, 0));                  // nothing to emit
    send(mk(OP_INV, 1, 1, 2, 2, 0, 0));
    send(mk(OP_POP, 0, 0, 0, 0, 0, 0));
    send(mk(OP_POP, 0, 0, 0, 0, 0, 65535));                // oversized pop
    send(mk(OP_INV, 3, 3, 4, 4, 0, 0));
    send(mk(OP_INV, 7, 7, 8, 8, 1, 0));
    send(mk(OP_CLR, 0, 0, 0, 0, 0, 0));
    send(mk(OP_POP, 0, 0, 0, 0, 0, 1));
    send(mk(OP_FLUSH, 0, 0, 0, 0, 0, 0));
    drain();

    // tiny screen: lots of containment and joining
    set_screen(16, 12);
    random_run(40);
    drain();   // sender holds off until every result item is back
    random_run(40);
    drain();

    set_screen(1, 1);
    random_run(20);
    drain();

    // largest screen, with a long stretch without idling
    calm = 1'b1;
    set_screen(4096, 4096);
    random_run(50);
    drain();
    calm = 1'b0;

    set_screen(0, 8191);
    random_run(20);
    drain();
    set_screen(8191, 0);
    random_run(20);
    drain();

    // overflow: distinct pixels until the buffer restarts with the whole screen
    set_screen(64, 64);
    for (int k = 0; k < 36; k++) send(mk(OP_INV, k, k, k, k, k & 1, 0));
    send(mk(OP_FLUSH, 0, 0, 0, 0, 0, 0));
    random_run(30);
    drain();

    set_screen($urandom_range(8191), $urandom_range(8191));
    random_run(40);
    send(mk(OP_FLUSH, 0, 0, 0, 0, 0, 0));
    drain();
    repeat (50) @(posedge clk);

    if (fails == 0 && pending == 0) begin
      $display("dirty_area_tracker regression: pass");
    end else begin
      $display("dirty_area_tracker regression: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/dat_pkg.sv
hdl/dat_if.sv
hdl/dat_ram.sv
hdl/dirty_area_tracker.sv
hdl/dat_checker.sv
dv/dat_checker.sv
dv/tb.sv
